[rtl/core/pcu_pkg.sv]
`timescale 1ns / 1ps
// shared types and the parameter count rom of the packed command unpacker
// no dependencies

package pcu_pkg;

    localparam int WordWidth  = 32;
    localparam int CmdWidth   = 8;
    localparam int CountWidth = 6;

    typedef enum logic [0:0] {
        PCU_IDLE  = 1'b0,
        PCU_DRAIN = 1'b1
    } pcu_state_t;

    // number of parameter words each command byte takes
    function automatic logic [CountWidth-1:0] cmd_arg_count(input logic [CmdWidth-1:0] cmd);
        logic [CountWidth-1:0] cnt;
        case (cmd) inside
            8'h10, 8'h12, 8'h13, 8'h14:    cnt = 6'd1;
            8'h16, 8'h18:                  cnt = 6'd16;
            8'h17, 8'h19:                  cnt = 6'd12;
            8'h1A:                         cnt = 6'd9;
            8'h1B, 8'h1C:                  cnt = 6'd3;
            8'h23:                         cnt = 6'd2;
            [8'h20:8'h2B]:                 cnt = 6'd1;
            [8'h30:8'h33]:                 cnt = 6'd1;
            8'h34:                         cnt = 6'd32;
            8'h40, 8'h50, 8'h60, 8'h72:    cnt = 6'd1;
            8'h70:                         cnt = 6'd3;
            8'h71:                         cnt = 6'd2;
            default:                       cnt = 6'd0;
        endcase
        return cnt;
    endfunction

endpackage

[rtl/core/packed_command_unpacker.sv]
`timescale 1ns / 1ps
// packed command unpacker: splits packed command words into command/argument results
// depends on pcu_pkg (state type, parameter count rom)
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------
//  input    | word_valid / word_ready    | word[31:0]
//  result   | result_valid / result_ready| command[7:0], argument[31:0],
//           |                            | last_of_run
//
// a word is taken while idle, then its results leave one per cycle as the
// held command word shifts down one byte per emitted command; a word
// releases up to 4 results, and no new word is taken until the last is emitted.
// the single output register sets the pace; a stalled result holds the drain.
// reset clears the held command word, the counter and the output valid.

module packed_command_unpacker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        word_valid,
    output logic        word_ready,
    input  logic [31:0] word,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  command,
    output logic [31:0] argument,
    output logic        last_of_run
);

    pcu_pkg::pcu_state_t state_reg, state_next;

    logic [pcu_pkg::WordWidth-1:0]  packed_reg;
    logic [pcu_pkg::WordWidth-1:0]  hold_reg;
    logic                           pending_reg;
    logic [pcu_pkg::CountWidth-1:0] taken_reg;

    logic                           result_valid_reg;
    logic [pcu_pkg::CmdWidth-1:0]   command_reg;
    logic [pcu_pkg::WordWidth-1:0]  argument_reg;
    logic                           last_reg;

    logic                           word_acc;
    logic [pcu_pkg::CmdWidth-1:0]   cmd_low;
    logic [pcu_pkg::CountWidth-1:0] cnt_low;
    logic [pcu_pkg::CountWidth-1:0] taken_inc;
    logic                           param_done;
    logic                           slot_free;
    logic                           emit_param;
    logic                           emit_zero;
    logic                           emit;
    logic                           shift_en;
    logic                           no_work;
    logic [pcu_pkg::WordWidth-1:0]  packed_after;
    logic                           run_end;

    // datapath decode
    always_comb
    begin
        cmd_low      = packed_reg[pcu_pkg::CmdWidth-1:0];
        cnt_low      = pcu_pkg::cmd_arg_count(cmd_low);
        taken_inc    = taken_reg + 6'd1;
        param_done   = (taken_inc == cnt_low);
        slot_free    = !result_valid_reg || result_ready;
        no_work      = !pending_reg && ((packed_reg == '0) || (cnt_low != '0));
        emit_param   = (state_reg == pcu_pkg::PCU_DRAIN) && pending_reg && slot_free;
        emit_zero    = (state_reg == pcu_pkg::PCU_DRAIN) && !pending_reg && !no_work
                       && slot_free;
        emit         = emit_param || emit_zero;
        shift_en     = emit_zero || (emit_param && param_done);
        packed_after = shift_en ? {8'h00, packed_reg[pcu_pkg::WordWidth-1:pcu_pkg::CmdWidth]}
                                : packed_reg;
        // the run ends when nothing is held or the next command waits for parameters
        run_end      = (packed_after == '0)
                       || (pcu_pkg::cmd_arg_count(packed_after[pcu_pkg::CmdWidth-1:0]) != '0);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcu_pkg::PCU_IDLE:
            begin
                if (word_acc)
                begin
                    state_next = pcu_pkg::PCU_DRAIN;
                end
            end
            pcu_pkg::PCU_DRAIN:
            begin
                if (emit)
                begin
                    state_next = run_end ? pcu_pkg::PCU_IDLE : pcu_pkg::PCU_DRAIN;
                end
                else if (no_work)
                begin
                    state_next = pcu_pkg::PCU_IDLE;
                end
            end
            default:
            begin
                state_next = pcu_pkg::PCU_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        word_ready   = (state_reg == pcu_pkg::PCU_IDLE);
        word_acc     = word_valid && word_ready;
        result_valid = result_valid_reg;
        command      = command_reg;
        argument     = argument_reg;
        last_of_run  = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pcu_pkg::PCU_IDLE;
            packed_reg       <= '0;
            taken_reg        <= '0;
            pending_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (word_acc)
            begin
                if (packed_reg == '0)
                begin
                    packed_reg <= word;
                end
                else
                begin
                    pending_reg <= 1'b1;
                end
            end
            else if (emit)
            begin
                packed_reg  <= packed_after;
                pending_reg <= 1'b0;
                if (emit_param)
                begin
                    taken_reg <= param_done ? '0 : taken_inc;
                end
            end
            if (emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (word_acc)
        begin
            hold_reg <= word;
        end
        if (emit)
        begin
            command_reg  <= cmd_low;
            argument_reg <= emit_param ? hold_reg : '0;
            last_reg     <= run_end;
        end
    end

    // an idle block never holds a leading command that needs no parameters
    a_idle_settled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcu_pkg::PCU_IDLE && packed_reg != '0)
        |-> (cnt_low != '0))
        else $error("idle with a parameterless command still held");

    // a parameter word never waits while the block is idle
    a_no_pending_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcu_pkg::PCU_IDLE) |-> !pending_reg)
        else $error("parameter pending while idle");

    // a counted parameter implies a held command
    a_count_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (taken_reg != '0) |-> (packed_reg != '0 && taken_reg < cnt_low))
        else $error("parameter count without a matching held command");

    // the last result of a run returns the block to idle
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && run_end) |=> (state_reg == pcu_pkg::PCU_IDLE && last_reg))
        else $error("run end did not return to idle");

endmodule
